// ----- hw/rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and lane types for the quaternion vector rotation core.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int QUAT_BITS   = 16;
   localparam int VECTOR_BITS = 24;

   // quaternion products, x*y etc.
   localparam int PROD_W = 2 * QUAT_BITS;
   // matrix numerators and n, |m| <= n <= 4 * 2^(2*QUAT_BITS-2)
   localparam int MAT_W  = PROD_W + 3;
   // vector times numerator
   localparam int MUL_W  = VECTOR_BITS + MAT_W;
   // dot product of three terms
   localparam int DOT_W  = MUL_W + 2;
   // remainder in the divider
   localparam int REM_W  = DOT_W;
   // |result| <= sqrt(3) * 2^(VECTOR_BITS-1)
   localparam int QUO_W  = VECTOR_BITS + 1;
   localparam int LANES  = 3;

   typedef logic signed [QUAT_BITS-1:0]   quat_type;
   typedef logic signed [VECTOR_BITS-1:0] vec_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [MAT_W-1:0]       mat_type;
   typedef logic signed [MUL_W-1:0]       mul_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic [REM_W-1:0]              rem_type;
   typedef logic [QUO_W-1:0]              quo_type;

endpackage

// ----- hw/rtl/quaternion_vector_rotate_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates a row vector by the matrix of a quaternion of any length.
// ----------------------------------------------------------------------------
//
// channel | ports                              | direction | beat
// --------+------------------------------------+-----------+------------------
// req     | quat_x/y/z/w, vec_x/y/z            | in        | valid & ready
// rsp     | out_x/y/z, zero_quat_error, sat.   | out       | valid & ready
//
// One beat in and one beat out per clock while rsp does not stall. Pipeline
// registers, in order: products, matrix numerators, vector products, dot
// product, 25 restoring divide stages (one quotient bit each, this sets the
// depth) and the clip/output register. Synchronous reset clears only the
// valid bits. A stall on rsp holds every stage at once; req_ready drops only
// while the output register is full and rsp_ready is low.
module quaternion_vector_rotate_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  qvr_pkg::quat_type      req_quat_x,
   input  qvr_pkg::quat_type      req_quat_y,
   input  qvr_pkg::quat_type      req_quat_z,
   input  qvr_pkg::quat_type      req_quat_w,
   input  qvr_pkg::vec_type       req_vec_x,
   input  qvr_pkg::vec_type       req_vec_y,
   input  qvr_pkg::vec_type       req_vec_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output qvr_pkg::vec_type       rsp_out_x,
   output qvr_pkg::vec_type       rsp_out_y,
   output qvr_pkg::vec_type       rsp_out_z,
   output logic                   rsp_zero_quat_error,
   output logic                   rsp_saturated
);
   import qvr_pkg::*;

   localparam int DIV_STAGES = QUO_W;

   logic adv;

   // ---------------- stage 1: quaternion products ----------------
   logic     s1_vld_ff, s1_zero_ff;
   prod_type s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_ww_ff;
   prod_type s1_xy_ff, s1_xz_ff, s1_yz_ff, s1_wx_ff, s1_wy_ff, s1_wz_ff;
   vec_type  s1_vec_ff [LANES];

   // ---------------- stage 2: matrix numerators ----------------
   logic    s2_vld_ff, s2_zero_ff;
   mat_type s2_n_ff;
   mat_type s2_m_ff [9];          // row major, m[r*3+c]
   vec_type s2_vec_ff [LANES];
   mat_type s2_n_in;
   mat_type s2_m_in [9];

   // ---------------- stage 3: vector times numerators ----------------
   logic    s3_vld_ff, s3_zero_ff;
   mat_type s3_n_ff;
   mul_type s3_p_ff [9];          // p[r*3+c] = v[r] * m[r*3+c]

   // ---------------- divider pipeline, index 0 is the dot product stage ----
   logic    d_vld_ff  [DIV_STAGES+1];
   logic    d_zero_ff [DIV_STAGES+1];
   mat_type d_n_ff    [DIV_STAGES+1];
   rem_type d_rem_ff  [DIV_STAGES+1][LANES];
   quo_type d_quo_ff  [DIV_STAGES+1][LANES];
   logic    d_neg_ff  [DIV_STAGES+1][LANES];

   // ---------------- output register ----------------
   logic    o_vld_ff, o_zero_ff, o_sat_ff;
   vec_type o_res_ff [LANES];
   vec_type o_res_in [LANES];
   logic    o_sat_in;

   assign adv       = !o_vld_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xx_ff     <= req_quat_x * req_quat_x;
         s1_yy_ff     <= req_quat_y * req_quat_y;
         s1_zz_ff     <= req_quat_z * req_quat_z;
         s1_ww_ff     <= req_quat_w * req_quat_w;
         s1_xy_ff     <= req_quat_x * req_quat_y;
         s1_xz_ff     <= req_quat_x * req_quat_z;
         s1_yz_ff     <= req_quat_y * req_quat_z;
         s1_wx_ff     <= req_quat_w * req_quat_x;
         s1_wy_ff     <= req_quat_w * req_quat_y;
         s1_wz_ff     <= req_quat_w * req_quat_z;
         s1_zero_ff   <= (req_quat_x == '0) && (req_quat_y == '0) &&
                         (req_quat_z == '0) && (req_quat_w == '0);
         s1_vec_ff[0] <= req_vec_x;
         s1_vec_ff[1] <= req_vec_y;
         s1_vec_ff[2] <= req_vec_z;
      end
   end

   // stage 2: n and the nine numerators over n
   always_comb begin
      mat_type xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
      xx = MAT_W'(s1_xx_ff);
      yy = MAT_W'(s1_yy_ff);
      zz = MAT_W'(s1_zz_ff);
      ww = MAT_W'(s1_ww_ff);
      xy = MAT_W'(s1_xy_ff);
      xz = MAT_W'(s1_xz_ff);
      yz = MAT_W'(s1_yz_ff);
      wx = MAT_W'(s1_wx_ff);
      wy = MAT_W'(s1_wy_ff);
      wz = MAT_W'(s1_wz_ff);
      // zero quaternion: n forced to one so the divider stays defined,
      // the result is cleared at the output register
      s2_n_in    = s1_zero_ff ? MAT_W'(1) : (xx + yy + zz + ww);
      s2_m_in[0] = s2_n_in - ((yy + zz) <<< 1);
      s2_m_in[1] = (xy + wz) <<< 1;
      s2_m_in[2] = (xz - wy) <<< 1;
      s2_m_in[3] = (xy - wz) <<< 1;
      s2_m_in[4] = s2_n_in - ((xx + zz) <<< 1);
      s2_m_in[5] = (yz + wx) <<< 1;
      s2_m_in[6] = (xz + wy) <<< 1;
      s2_m_in[7] = (yz - wx) <<< 1;
      s2_m_in[8] = s2_n_in - ((xx + yy) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_zero_ff <= s1_zero_ff;
         s2_n_ff    <= s2_n_in;
         s2_m_ff    <= s2_m_in;
         s2_vec_ff  <= s1_vec_ff;
      end
   end

   // stage 3: nine products
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_zero_ff <= s2_zero_ff;
         s3_n_ff    <= s2_n_ff;
         for (int i = 0; i < 9; i++) begin
            s3_p_ff[i] <= MUL_W'(s2_vec_ff[i / 3]) * MUL_W'(s2_m_ff[i]);
         end
      end
   end

   // stage 4: column dot products, magnitude plus half of n for rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         d_vld_ff[0] <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_zero_ff[0] <= s3_zero_ff;
         d_n_ff[0]    <= s3_n_ff;
         for (int c = 0; c < LANES; c++) begin
            dot_type dot;
            dot = DOT_W'(s3_p_ff[c]) + DOT_W'(s3_p_ff[3 + c]) + DOT_W'(s3_p_ff[6 + c]);
            d_neg_ff[0][c] <= dot[DOT_W-1];
            d_rem_ff[0][c] <= (dot[DOT_W-1] ? rem_type'(-dot) : rem_type'(dot))
                              + rem_type'(s3_n_ff >>> 1);
            d_quo_ff[0][c] <= '0;
         end
      end
   end

   // restoring divide, one quotient bit per stage, MSB first
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int BIT = DIV_STAGES - 1 - j;
      rem_type dvs;
      assign dvs = rem_type'(d_n_ff[j]) << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[j+1] <= d_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_zero_ff[j+1] <= d_zero_ff[j];
            d_n_ff[j+1]    <= d_n_ff[j];
            for (int c = 0; c < LANES; c++) begin
               d_neg_ff[j+1][c] <= d_neg_ff[j][c];
               if (d_rem_ff[j][c] >= dvs) begin
                  d_rem_ff[j+1][c] <= d_rem_ff[j][c] - dvs;
                  d_quo_ff[j+1][c] <= d_quo_ff[j][c] | (quo_type'(1) << BIT);
               end else begin
                  d_rem_ff[j+1][c] <= d_rem_ff[j][c];
                  d_quo_ff[j+1][c] <= d_quo_ff[j][c];
               end
            end
         end
      end
   end

   // sign, clip to the vector range
   always_comb begin
      logic signed [QUO_W:0] res;
      logic signed [QUO_W:0] hi, lo;
      hi       = (QUO_W+1)'({1'b0, {(VECTOR_BITS-1){1'b1}}});
      lo       = -hi - (QUO_W+1)'(1);
      o_sat_in = 1'b0;
      for (int c = 0; c < LANES; c++) begin
         res = d_neg_ff[DIV_STAGES][c] ? -$signed({1'b0, d_quo_ff[DIV_STAGES][c]})
                                       :  $signed({1'b0, d_quo_ff[DIV_STAGES][c]});
         if (res > hi) begin
            o_res_in[c] = hi[VECTOR_BITS-1:0];
            o_sat_in    = 1'b1;
         end else if (res < lo) begin
            o_res_in[c] = lo[VECTOR_BITS-1:0];
            o_sat_in    = 1'b1;
         end else begin
            o_res_in[c] = res[VECTOR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= d_vld_ff[DIV_STAGES];
      end
   end

   // zero quaternion: outputs cleared, no saturation
   always_ff @(posedge clock) begin
      if (adv) begin
         o_zero_ff <= d_zero_ff[DIV_STAGES];
         o_sat_ff  <= o_sat_in && !d_zero_ff[DIV_STAGES];
         for (int c = 0; c < LANES; c++) begin
            o_res_ff[c] <= d_zero_ff[DIV_STAGES] ? '0 : o_res_in[c];
         end
      end
   end

   assign rsp_valid           = o_vld_ff;
   assign rsp_out_x           = o_res_ff[0];
   assign rsp_out_y           = o_res_ff[1];
   assign rsp_out_z           = o_res_ff[2];
   assign rsp_zero_quat_error = o_zero_ff;
   assign rsp_saturated       = o_sat_ff;

endmodule

// ----- tb/quaternion_vector_rotate_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core_tb
// Self-checking bench for the quaternion vector rotation core. Directed
// corner beats, then random quaternions and vectors, are pushed through a
// bursty sender against a stalling receiver; every response beat is checked
// against an exact integer rotation computed in the bench.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core_tb;
   import qvr_pkg::*;

   typedef struct {
      quat_type qx, qy, qz, qw;
      vec_type  vx, vy, vz;
   } req_beat_type;

   typedef struct {
      vec_type ox, oy, oz;
      logic    zero_err;
      logic    sat;
   } rsp_beat_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   quat_type req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   vec_type  req_vec_x, req_vec_y, req_vec_z;
   logic     rsp_valid;
   logic     rsp_ready;
   vec_type  rsp_out_x, rsp_out_y, rsp_out_z;
   logic     rsp_zero_quat_error;
   logic     rsp_saturated;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rotations[$];
   bit        stimulus_done;
   bit        drain_hold;   // sender holds off until all responses are back
   int        errors;
   int        gap_left;
   int        burst_left;
   int        stall_phase;

   quaternion_vector_rotate_core uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // rounded division, ties away from zero; den is always positive here
   function automatic longint div_round(longint num, longint den);
      longint q;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic vec_type clamp_vec(longint v, ref logic sat);
      longint hi, lo;
      hi = (64'sd1 <<< (VECTOR_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return vec_type'(hi);
      end
      if (v < lo) begin
         sat = 1'b1;
         return vec_type'(lo);
      end
      return vec_type'(v);
   endfunction

   // Exact rotation: numerators over n, one rounding step, then clamp.
   // Quaternion magnitudes never exceed 32768 at 16 bits, so no prescale.
   function automatic rsp_beat_type rotate_vector(req_beat_type b);
      rsp_beat_type r;
      longint x, y, z, w, vx, vy, vz, n;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
      x = b.qx; y = b.qy; z = b.qz; w = b.qw;
      vx = b.vx; vy = b.vy; vz = b.vz;
      r.sat = 1'b0;
      r.zero_err = 1'b0;
      if (x == 0 && y == 0 && z == 0 && w == 0) begin
         r.ox = '0; r.oy = '0; r.oz = '0;
         r.zero_err = 1'b1;
         return r;
      end
      xx = x * x; yy = y * y; zz = z * z;
      xy = x * y; xz = x * z; yz = y * z;
      wx = w * x; wy = w * y; wz = w * z;
      n = xx + yy + zz + w * w;
      m00 = n - 2 * (yy + zz); m01 = 2 * (xy + wz); m02 = 2 * (xz - wy);
      m10 = 2 * (xy - wz); m11 = n - 2 * (xx + zz); m12 = 2 * (yz + wx);
      m20 = 2 * (xz + wy); m21 = 2 * (yz - wx); m22 = n - 2 * (xx + yy);
      r.ox = clamp_vec(div_round(vx * m00 + vy * m10 + vz * m20, n), r.sat);
      r.oy = clamp_vec(div_round(vx * m01 + vy * m11 + vz * m21, n), r.sat);
      r.oz = clamp_vec(div_round(vx * m02 + vy * m12 + vz * m22, n), r.sat);
      return r;
   endfunction

   function automatic quat_type rand_quat();
      case ($urandom_range(0, 5))
         0: return quat_type'($urandom_range(0, 4) - 2);         // near zero
         1: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
         2: return quat_type'($urandom_range(0, 32768) - 16384); // unit range
         default: return quat_type'($urandom());
      endcase
   endfunction

   function automatic vec_type rand_vec();
      case ($urandom_range(0, 4))
         0: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
         1: return vec_type'($urandom_range(0, 2000) - 1000);
         default: return vec_type'($urandom());
      endcase
   endfunction

   task automatic queue_beat(quat_type qx, quat_type qy, quat_type qz, quat_type qw,
                             vec_type vx, vec_type vy, vec_type vz);
      req_beat_type b;
      b.qx = qx; b.qy = qy; b.qz = qz; b.qw = qw;
      b.vx = vx; b.vy = vy; b.vz = vz;
      pending_reqs.push_back(b);
   endtask

   // Sender: bursts of random length separated by random gaps. Valid stays
   // up with a steady payload until the beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else begin
         logic taken;
         logic next_valid;
         taken = req_valid && req_ready;
         if (taken) begin
            expected_rotations.push_back(rotate_vector(pending_reqs.pop_front()));
         end
         next_valid = req_valid && !taken;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0 && !drain_hold) begin
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 40);
                  if ($urandom_range(0, 2) != 0)
                     gap_left <= $urandom_range(1, 8);
               end
            end
         end
         if (next_valid) begin
            req_quat_x <= pending_reqs[0].qx;
            req_quat_y <= pending_reqs[0].qy;
            req_quat_z <= pending_reqs[0].qz;
            req_quat_w <= pending_reqs[0].qw;
            req_vec_x  <= pending_reqs[0].vx;
            req_vec_y  <= pending_reqs[0].vy;
            req_vec_z  <= pending_reqs[0].vz;
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: a phase counter sets the stall pattern; some windows never stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[9:8] == 2'd0)
            rsp_ready <= 1'b1;
         else if (stall_phase[9:8] == 2'd1)
            rsp_ready <= (stall_phase % 3) != 0;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor: check each response beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rotations.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            rsp_beat_type e;
            e = expected_rotations.pop_front();
            if (rsp_out_x !== e.ox) begin
               $error("out_x exp %0d got %0d", e.ox, rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.oy) begin
               $error("out_y exp %0d got %0d", e.oy, rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.oz) begin
               $error("out_z exp %0d got %0d", e.oz, rsp_out_z);
               errors++;
            end
            if (rsp_zero_quat_error !== e.zero_err) begin
               $error("zero_quat_error exp %0b got %0b", e.zero_err, rsp_zero_quat_error);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_quat_x = '0; req_quat_y = '0; req_quat_z = '0; req_quat_w = '0;
      req_vec_x = '0; req_vec_y = '0; req_vec_z = '0;
      errors = 0;
      stimulus_done = 1'b0;
      drain_hold = 1'b0;

      // directed: identity, zero quaternion, extremes, half turns, saturation
      queue_beat(0, 0, 0, 16384, 24'sh010000, -24'sh020000, 24'sh030000);
      queue_beat(0, 0, 0, 0, 24'sh7fffff, 24'sh800000, 24'sh000001);
      queue_beat(0, 0, 0, 0, 0, 0, 0);
      queue_beat(16384, 0, 0, 0, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
      queue_beat(0, 16384, 0, 0, 24'sh800000, 24'sh123456, 24'sh7fffff);
      queue_beat(0, 0, 16384, 0, 24'sh000001, -24'sh000001, 24'sh7fffff);
      queue_beat(11585, 0, 0, 11585, 24'sh100000, 24'sh200000, 24'sh300000);
      queue_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
      queue_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 24'sh800000, 24'sh800000, 24'sh800000);
      queue_beat(16'sh8000, 16'sh7fff, 0, 1, 24'sh7fffff, 24'sh800000, 24'sh7fffff);
      queue_beat(1, 0, 0, 0, 24'sh555555, 24'shaaaaaa, 24'sh7fffff);
      queue_beat(0, 0, 0, -1, 3, -3, 24'sh7fffff);
      queue_beat(1, 1, 1, 1, 24'sh7fffff, 24'sh7fffff, 0);  // diagonal, permutes lanes
      queue_beat(-1, 2, -3, 4, 1, 1, 1);                    // rounding of small results
      queue_beat(16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb,
                 24'shffffff, 24'sh000000, 24'shfffffe);
      wait (!reset);

      for (int i = 0; i < 1300; i++) begin
         if (i == 600) begin
            // hold the sender until the pipeline has fully drained
            wait (pending_reqs.size() == 0 && !req_valid);
            drain_hold = 1'b1;
            wait (expected_rotations.size() == 0);
            @(posedge clock);
            drain_hold = 1'b0;
         end
         queue_beat(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                    rand_vec(), rand_vec(), rand_vec());
         if (pending_reqs.size() > 64)
            wait (pending_reqs.size() < 32);
      end
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rotations.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // generous watchdog well beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
